>>> hw/rtl/cwt_pkg.sv
package cwt_pkg;

   // Field widths fixed by the block's programming model.
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned INDEX_W    = 16;
   localparam int unsigned CFG_W      = 11;
   localparam int unsigned SKIP_W     = 10;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned ERR_W      = 3;
   localparam int unsigned FIRST_W    = 10;
   localparam int unsigned SEQ_OUT_W  = 32;

   // Event kinds carried by an input item. Codes six and seven are unused.
   typedef enum logic [MODE_W-1:0] {
      MODE_FRAME   = 3'd0,
      MODE_TRASH   = 3'd1,
      MODE_ARM     = 3'd2,
      MODE_CANCEL  = 3'd3,
      MODE_TIMEOUT = 3'd4,
      MODE_RESTART = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE      = 3'd0,
      ST_ARMED     = 3'd1,
      ST_COMPLETE  = 3'd2,
      ST_CANCELLED = 3'd3,
      ST_TIMED_OUT = 3'd4,
      ST_TRASH     = 3'd5,
      ST_DISCONT   = 3'd6,
      ST_INVALID   = 3'd7
   } status_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK            = 3'd0,
      ERR_NO_BUFFERS    = 3'd1,
      ERR_BAD_FRAMES    = 3'd2,
      ERR_BAD_SKIP      = 3'd3,
      ERR_ALREADY_ARMED = 3'd4
   } arm_err_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_COUNT  = 2'd0,
      CSR_INITIAL_LAST  = 2'd1,
      CSR_CAPTURE_COUNT = 2'd2,
      CSR_SKIP_COUNT    = 2'd3
   } csr_index_type;

endpackage

>>> hw/rtl/cwt_if.sv
interface cwt_req_if;
   logic                                valid;
   logic                                ready;
   logic [cwt_pkg::MODE_W-1:0]          mode;
   logic signed [cwt_pkg::INDEX_W-1:0]  buffer_index;

   modport source (output valid, output mode, output buffer_index, input ready);
   modport sink   (input valid, input mode, input buffer_index, output ready);
endinterface

interface cwt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cwt_pkg::STATUS_W-1:0]      window_status;
   logic [cwt_pkg::ERR_W-1:0]         arm_error;
   logic [cwt_pkg::FIRST_W-1:0]       first_index;
   logic [cwt_pkg::SEQ_OUT_W-1:0]     first_sequence;
   logic [cwt_pkg::SEQ_OUT_W-1:0]     last_sequence;
   logic [cwt_pkg::CFG_W-1:0]         captured_count;
   logic [cwt_pkg::SEQ_OUT_W-1:0]     normal_frame_total;
   logic                              window_intact;

   modport source (
      output valid, output window_status, output arm_error, output first_index,
      output first_sequence, output last_sequence, output captured_count,
      output normal_frame_total, output window_intact, input ready
   );
   modport sink (
      input valid, input window_status, input arm_error, input first_index,
      input first_sequence, input last_sequence, input captured_count,
      input normal_frame_total, input window_intact, output ready
   );
endinterface

>>> hw/rtl/capture_window_tracker_core.sv
// Capture window tracker. Each input item is one event (frame with a buffer
// index, trash frame, arm, cancel, timeout or restart) and produces exactly
// one result item with the window status, the arm error code, the window's
// first index and sequence numbers, the captured count, the running count of
// valid frames and the intact flag. The block takes one item per clock; each
// item is held in the input register, then the tracking state is updated and
// the result written into the result register. Both stages keep moving while
// the next stage is free, so items stream at one per cycle; only a stalled
// result channel holds the pipe. Restart latches the ring size (saturated at
// MAX_BUFFERS or the buffer count register's maximum, if smaller) and the initial
// last index from the configuration registers; arm reads the capture and
// skip counts. Configuration should be written while no item is in flight.
// Sequence counters are SEQUENCE_BITS wide and wrap; the sequence outputs
// show their low 32 bits, zero extended when the counters are narrower.
module capture_window_tracker_core #(
   parameter int unsigned MAX_BUFFERS   = 1024,
   parameter int unsigned SEQUENCE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cwt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cwt_pkg::CFG_W-1:0]        csr_wdata,
   cwt_req_if.sink                          req_if,
   cwt_rsp_if.source                        rsp_if
);

   localparam int unsigned CFG_W  = cwt_pkg::CFG_W;
   localparam int unsigned SKIP_W = cwt_pkg::SKIP_W;
   localparam int unsigned SEQ_W  = SEQUENCE_BITS;
   localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
   // The ring size can never exceed what the buffer count register holds.
   localparam int unsigned RING_CAP_INT = (MAX_BUFFERS > CFG_MAX) ? CFG_MAX : MAX_BUFFERS;
   localparam logic [CFG_W-1:0] RING_CAP = CFG_W'(RING_CAP_INT);

   typedef struct packed {
      logic [cwt_pkg::STATUS_W-1:0]  window_status;
      logic [cwt_pkg::ERR_W-1:0]     arm_error;
      logic [cwt_pkg::FIRST_W-1:0]   first_index;
      logic [cwt_pkg::SEQ_OUT_W-1:0] first_sequence;
      logic [cwt_pkg::SEQ_OUT_W-1:0] last_sequence;
      logic [CFG_W-1:0]              captured_count;
      logic [cwt_pkg::SEQ_OUT_W-1:0] normal_frame_total;
      logic                          window_intact;
   } result_type;

   // Configuration registers.
   logic [CFG_W-1:0]  cfg_buffer_count_ff;
   logic [CFG_W-1:0]  cfg_initial_last_ff;
   logic [CFG_W-1:0]  cfg_capture_count_ff;
   logic [SKIP_W-1:0] cfg_skip_count_ff;

   // Input register stage.
   logic                              s1_valid_ff;
   logic [cwt_pkg::MODE_W-1:0]        s1_mode_ff;
   logic [cwt_pkg::INDEX_W-1:0]       s1_index_ff;

   // Tracking state.
   logic [CFG_W-1:0]                  ring_size_ff, ring_size_in;
   logic [cwt_pkg::STATUS_W-1:0]      state_ff, state_in;
   logic [CFG_W-1:0]                  last_index_ff, last_index_in;
   logic                              last_known_ff, last_known_in;
   logic [SKIP_W-1:0]                 skip_left_ff, skip_left_in;
   logic [CFG_W-1:0]                  target_ff, target_in;
   logic [CFG_W-1:0]                  count_ff, count_in;
   logic [SEQ_W-1:0]                  frame_total_ff, frame_total_in;
   logic [cwt_pkg::FIRST_W-1:0]       first_index_ff, first_index_in;
   logic [SEQ_W-1:0]                  first_seq_ff, first_seq_in;
   logic [SEQ_W-1:0]                  last_seq_ff, last_seq_in;
   // Frames counted since the first captured frame, which is what the
   // intact check needs; it equals frame_total minus first_seq in the
   // complete state.
   logic [SEQ_W-1:0]                  age_ff, age_in;

   // Result register.
   logic                              rsp_valid_ff;
   result_type                        rsp_ff;
   logic [cwt_pkg::ERR_W-1:0]         arm_err_in;
   logic                              intact_in;

   logic                              s2_go;
   logic                              idx_in_range;
   logic [CFG_W-1:0]                  idx_short;
   logic [CFG_W-1:0]                  expected_index;
   logic [CFG_W-1:0]                  count_plus;
   logic [SEQ_W-1:0]                  frame_total_plus;
   logic                              restart_known;

   // The update stage fires when an item waits in the input register and the
   // result register is empty or is being drained in this cycle.
   assign s2_go        = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s2_go;

   // A frame index counts only when it is non-negative and inside the ring.
   assign idx_in_range = !s1_index_ff[cwt_pkg::INDEX_W-1]
                      && ({1'b0, s1_index_ff[cwt_pkg::INDEX_W-2:0]}
                          < {{(cwt_pkg::INDEX_W-CFG_W){1'b0}}, ring_size_ff});
   assign idx_short    = s1_index_ff[CFG_W-1:0];

   // A known last index is always below the ring size, so wrapping around the
   // ring is a single compare.
   assign expected_index   = (last_index_ff + 1'b1 == ring_size_ff)
                             ? '0 : last_index_ff + 1'b1;
   assign count_plus       = count_ff + 1'b1;
   assign frame_total_plus = frame_total_ff + 1'b1;

   always_comb begin
      ring_size_in   = ring_size_ff;
      state_in       = state_ff;
      last_index_in  = last_index_ff;
      last_known_in  = last_known_ff;
      skip_left_in   = skip_left_ff;
      target_in      = target_ff;
      count_in       = count_ff;
      frame_total_in = frame_total_ff;
      first_index_in = first_index_ff;
      first_seq_in   = first_seq_ff;
      last_seq_in    = last_seq_ff;
      age_in         = age_ff;
      arm_err_in     = cwt_pkg::ERR_OK;
      restart_known  = 1'b0;

      unique case (s1_mode_ff)
         cwt_pkg::MODE_FRAME: begin
            if (!idx_in_range) begin
               if (state_ff == cwt_pkg::ST_ARMED) begin
                  state_in = cwt_pkg::ST_INVALID;
               end
            end else begin
               // A break in the index sequence fails the window, but the
               // frame is still tracked and counted.
               if (last_known_ff && (idx_short != expected_index)
                   && (state_ff == cwt_pkg::ST_ARMED)) begin
                  state_in = cwt_pkg::ST_DISCONT;
               end
               last_index_in  = idx_short;
               last_known_in  = 1'b1;
               frame_total_in = frame_total_plus;
               age_in         = age_ff + 1'b1;
               if (state_in == cwt_pkg::ST_ARMED) begin
                  if (skip_left_ff != '0) begin
                     skip_left_in = skip_left_ff - 1'b1;
                  end else begin
                     if (count_ff == '0) begin
                        first_index_in = idx_short[cwt_pkg::FIRST_W-1:0];
                        first_seq_in   = frame_total_plus;
                        age_in         = '0;
                     end
                     count_in    = count_plus;
                     last_seq_in = frame_total_plus;
                     if (count_plus == target_ff) begin
                        state_in = cwt_pkg::ST_COMPLETE;
                     end
                  end
               end
            end
         end
         cwt_pkg::MODE_TRASH: begin
            if (state_ff == cwt_pkg::ST_ARMED) begin
               state_in = cwt_pkg::ST_TRASH;
            end
         end
         cwt_pkg::MODE_ARM: begin
            if (ring_size_ff == '0) begin
               arm_err_in = cwt_pkg::ERR_NO_BUFFERS;
            end else if ((cfg_capture_count_ff == '0)
                         || (cfg_capture_count_ff > ring_size_ff)) begin
               arm_err_in = cwt_pkg::ERR_BAD_FRAMES;
            end else if ({1'b0, cfg_skip_count_ff} >= ring_size_ff) begin
               arm_err_in = cwt_pkg::ERR_BAD_SKIP;
            end else if (state_ff == cwt_pkg::ST_ARMED) begin
               arm_err_in = cwt_pkg::ERR_ALREADY_ARMED;
            end else begin
               skip_left_in   = cfg_skip_count_ff;
               target_in      = cfg_capture_count_ff;
               count_in       = '0;
               first_index_in = '0;
               first_seq_in   = '0;
               last_seq_in    = '0;
               state_in       = cwt_pkg::ST_ARMED;
            end
         end
         cwt_pkg::MODE_CANCEL: begin
            if (state_ff == cwt_pkg::ST_ARMED) begin
               state_in = cwt_pkg::ST_CANCELLED;
            end
         end
         cwt_pkg::MODE_TIMEOUT: begin
            if (state_ff == cwt_pkg::ST_ARMED) begin
               state_in = cwt_pkg::ST_TIMED_OUT;
            end
         end
         cwt_pkg::MODE_RESTART: begin
            ring_size_in = (cfg_buffer_count_ff > RING_CAP) ? RING_CAP : cfg_buffer_count_ff;
            // The initial last index is signed; a negative or out-of-ring
            // value leaves the last index unknown.
            restart_known = (ring_size_in != '0) && !cfg_initial_last_ff[CFG_W-1]
                         && ({1'b0, cfg_initial_last_ff[CFG_W-2:0]} < ring_size_in);
            last_index_in  = restart_known ? {1'b0, cfg_initial_last_ff[CFG_W-2:0]} : '0;
            last_known_in  = restart_known;
            frame_total_in = '0;
            skip_left_in   = '0;
            target_in      = '0;
            count_in       = '0;
            state_in       = cwt_pkg::ST_IDLE;
            first_index_in = '0;
            first_seq_in   = '0;
            last_seq_in    = '0;
            age_in         = '0;
         end
         default: begin
         end
      endcase

      intact_in = (state_in == cwt_pkg::ST_COMPLETE) && (ring_size_in != '0)
               && (age_in < SEQ_W'(ring_size_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_buffer_count_ff  <= '0;
         cfg_initial_last_ff  <= '1;
         cfg_capture_count_ff <= '0;
         cfg_skip_count_ff    <= '0;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         ring_size_ff         <= '0;
         state_ff             <= cwt_pkg::ST_IDLE;
         last_index_ff        <= '0;
         last_known_ff        <= 1'b0;
         skip_left_ff         <= '0;
         target_ff            <= '0;
         count_ff             <= '0;
         frame_total_ff       <= '0;
         first_index_ff       <= '0;
         first_seq_ff         <= '0;
         last_seq_ff          <= '0;
         age_ff               <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               cwt_pkg::CSR_BUFFER_COUNT:  cfg_buffer_count_ff  <= csr_wdata;
               cwt_pkg::CSR_INITIAL_LAST:  cfg_initial_last_ff  <= csr_wdata;
               cwt_pkg::CSR_CAPTURE_COUNT: cfg_capture_count_ff <= csr_wdata;
               cwt_pkg::CSR_SKIP_COUNT:    cfg_skip_count_ff    <= csr_wdata[SKIP_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_if.valid && req_if.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s2_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (s2_go) begin
            ring_size_ff   <= ring_size_in;
            state_ff       <= state_in;
            last_index_ff  <= last_index_in;
            last_known_ff  <= last_known_in;
            skip_left_ff   <= skip_left_in;
            target_ff      <= target_in;
            count_ff       <= count_in;
            frame_total_ff <= frame_total_in;
            first_index_ff <= first_index_in;
            first_seq_ff   <= first_seq_in;
            last_seq_ff    <= last_seq_in;
            age_ff         <= age_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_mode_ff  <= req_if.mode;
         s1_index_ff <= req_if.buffer_index;
      end
      if (s2_go) begin
         rsp_ff.window_status      <= state_in;
         rsp_ff.arm_error          <= arm_err_in;
         rsp_ff.first_index        <= first_index_in;
         rsp_ff.first_sequence     <= cwt_pkg::SEQ_OUT_W'(first_seq_in);
         rsp_ff.last_sequence      <= cwt_pkg::SEQ_OUT_W'(last_seq_in);
         rsp_ff.captured_count     <= count_in;
         rsp_ff.normal_frame_total <= cwt_pkg::SEQ_OUT_W'(frame_total_in);
         rsp_ff.window_intact      <= intact_in;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.window_status      = rsp_ff.window_status;
   assign rsp_if.arm_error          = rsp_ff.arm_error;
   assign rsp_if.first_index        = rsp_ff.first_index;
   assign rsp_if.first_sequence     = rsp_ff.first_sequence;
   assign rsp_if.last_sequence      = rsp_ff.last_sequence;
   assign rsp_if.captured_count     = rsp_ff.captured_count;
   assign rsp_if.normal_frame_total = rsp_ff.normal_frame_total;
   assign rsp_if.window_intact      = rsp_ff.window_intact;

   // The window never captures more frames than its target.
   a_count_le_target: assert property (@(posedge clock) disable iff (reset)
      count_ff <= target_ff)
      else $error("captured count exceeds target");

   // A known last index always lies inside the latched ring.
   a_last_in_ring: assert property (@(posedge clock) disable iff (reset)
      last_known_ff |-> (last_index_ff < ring_size_ff))
      else $error("last index outside ring");

   // An intact window is only ever reported together with a complete status.
   a_intact_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.window_intact)
      |-> (rsp_ff.window_status == cwt_pkg::ST_COMPLETE))
      else $error("intact flag without complete status");

   // An item in the input register is not dropped while the result stalls.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_go) |=> s1_valid_ff)
      else $error("input stage lost an item");

endmodule
